>>> hw/rtl/ttps_pkg.sv
package ttps_pkg;

    localparam int MASK_W  = 12;
    localparam int HASH_W  = 64;
    localparam int DEPTH_W = 8;
    localparam int SCORE_W = 16;
    localparam int BOUND_W = 2;
    localparam int MOVE_W  = 8;

    localparam logic OP_PROBE = 1'b0;
    localparam logic OP_STORE = 1'b1;

    localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
    localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd1;
    localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd2;

    typedef struct packed {
        logic                      opcode;
        logic [HASH_W-1:0]         position_hash;
        logic [DEPTH_W-1:0]        search_depth;
        logic signed [SCORE_W-1:0] alpha;
        logic signed [SCORE_W-1:0] beta;
        logic signed [SCORE_W-1:0] store_value;
        logic [BOUND_W-1:0]        store_flags;
        logic [MOVE_W-1:0]         store_move;
        logic                      time_expired;
    } req_t;

    typedef struct packed {
        logic                      tag_hit;
        logic [MOVE_W-1:0]         hit_move;
        logic                      value_valid;
        logic signed [SCORE_W-1:0] result_value;
    } rsp_t;

    typedef struct packed {
        logic                      valid;
        logic [HASH_W-1:0]         tag;
        logic signed [SCORE_W-1:0] value;
        logic [BOUND_W-1:0]        bound;
        logic [DEPTH_W-1:0]        depth;
        logic [MOVE_W-1:0]         move;
    } entry_t;

    localparam int REQ_W   = $bits(req_t);
    localparam int RSP_W   = $bits(rsp_t);
    localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> hw/rtl/ttps_ram.sv
module ttps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

>>> hw/rtl/ttps_fifo.sv
module ttps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> hw/rtl/ttps_front.sv
module ttps_front #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ttps_pkg::MASK_W-1:0]          cfg_data,
    input  logic                                 push,
    input  ttps_pkg::req_t                       request,
    output logic                                 full,
    input  logic                                 clearing,
    output logic                                 work_push,
    output logic [ttps_pkg::REQ_W+$clog2(TABLE_ENTRIES):0] work_data,
    input  logic                                 work_full
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int MASK_W  = ttps_pkg::MASK_W;
    localparam int SHIFT   = MASK_W + IDX_W;
    localparam int RECIP_W = MASK_W + 1;
    localparam int PROD_W  = MASK_W + RECIP_W;
    localparam int REM_W   = MASK_W + IDX_W + 1;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam logic [IDX_W:0]     NUM   = (IDX_W + 1)'(TABLE_ENTRIES);

    logic [MASK_W-1:0] index_mask_reg;
    logic              s1_valid_reg, s1_valid_next;
    ttps_pkg::req_t    s1_req_reg;
    logic [MASK_W-1:0] s1_v_reg;
    logic [MASK_W-1:0] s1_q_reg;
    logic              s1_dis_reg;

    logic              accept;
    logic              advance;
    logic [MASK_W-1:0] masked;
    logic [PROD_W-1:0] prod;
    logic [REM_W-1:0]  qn;
    logic [REM_W-1:0]  rem;
    logic [IDX_W-1:0]  idx;

    assign full      = clearing || (s1_valid_reg && work_full);
    assign accept    = push && !full;
    assign advance   = s1_valid_reg && !work_full;
    assign work_push = advance;

    assign masked = request.position_hash[MASK_W-1:0] & index_mask_reg;
    assign prod   = PROD_W'(masked) * PROD_W'(RECIP);

    assign qn        = REM_W'(s1_q_reg) * REM_W'(NUM);
    assign rem       = REM_W'(s1_v_reg) - qn;
    assign idx       = rem[IDX_W-1:0];
    assign work_data = {s1_dis_reg, idx, s1_req_reg};

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_mask_reg <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                index_mask_reg <= cfg_data;
            end
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= request;
            s1_v_reg   <= masked;
            s1_q_reg   <= MASK_W'(prod >> SHIFT);
            s1_dis_reg <= (index_mask_reg == '0);
        end
    end

endmodule

>>> hw/rtl/ttps_back.sv
module ttps_back #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 work_valid,
    input  logic [ttps_pkg::REQ_W+$clog2(TABLE_ENTRIES):0] work_data,
    output logic                                 work_pop,
    output logic                                 clearing,
    output logic                                 rsp_push,
    output ttps_pkg::rsp_t                       rsp_data,
    input  logic                                 rsp_full
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int REQ_W = ttps_pkg::REQ_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] clr_addr_reg;
    ttps_pkg::req_t   cur_req_reg;
    logic [IDX_W-1:0] cur_idx_reg;
    logic             cur_dis_reg;

    ttps_pkg::req_t   w_req;
    logic [IDX_W-1:0] w_idx;
    logic             w_dis;

    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    logic [ttps_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]              ram_raddr;
    logic [ttps_pkg::ENTRY_W-1:0]  ram_rdata;
    ttps_pkg::entry_t              rd;
    ttps_pkg::entry_t              new_entry;

    logic           finish;
    logic           match;
    logic           keep;
    logic           score_ok;
    logic signed [ttps_pkg::SCORE_W-1:0] score;
    ttps_pkg::rsp_t probe_rsp;

    assign w_req = ttps_pkg::req_t'(work_data[REQ_W-1:0]);
    assign w_idx = work_data[REQ_W +: IDX_W];
    assign w_dis = work_data[REQ_W + IDX_W];

    assign clearing = (state_reg == ST_CLEAR);
    assign work_pop = (state_reg == ST_IDLE) && work_valid;
    assign finish   = (state_reg == ST_LOOKUP) && !rsp_full;
    assign rsp_push = finish;

    // hold the read on the current entry while the lookup stalls
    assign ram_raddr = (state_reg == ST_IDLE) ? w_idx : cur_idx_reg;

    assign rd    = ttps_pkg::entry_t'(ram_rdata);
    assign match = rd.valid && (rd.tag == cur_req_reg.position_hash);
    assign keep  = match && (rd.depth > cur_req_reg.search_depth);

    always_comb
    begin
        score_ok = 1'b0;
        score    = '0;
        if (rd.depth >= cur_req_reg.search_depth)
        begin
            case (rd.bound)
                ttps_pkg::BOUND_EXACT:
                begin
                    score_ok = 1'b1;
                    score    = rd.value;
                end
                ttps_pkg::BOUND_UPPER:
                begin
                    if ($signed(rd.value) <= $signed(cur_req_reg.alpha))
                    begin
                        score_ok = 1'b1;
                        score    = cur_req_reg.alpha;
                    end
                end
                ttps_pkg::BOUND_LOWER:
                begin
                    if ($signed(rd.value) >= $signed(cur_req_reg.beta))
                    begin
                        score_ok = 1'b1;
                        score    = cur_req_reg.beta;
                    end
                end
                default:
                begin
                    score_ok = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        probe_rsp = '0;
        if (match)
        begin
            probe_rsp.tag_hit     = 1'b1;
            probe_rsp.hit_move    = rd.move;
            probe_rsp.value_valid = score_ok;
            probe_rsp.result_value = score_ok ? score : '0;
        end
    end

    always_comb
    begin
        rsp_data = '0;
        if (!cur_dis_reg && (cur_req_reg.opcode == ttps_pkg::OP_PROBE))
        begin
            rsp_data = probe_rsp;
        end
    end

    always_comb
    begin
        new_entry.valid = 1'b1;
        new_entry.tag   = cur_req_reg.position_hash;
        new_entry.value = cur_req_reg.store_value;
        new_entry.bound = cur_req_reg.store_flags;
        new_entry.depth = cur_req_reg.search_depth;
        new_entry.move  = cur_req_reg.store_move;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cur_idx_reg;
        ram_wdata = new_entry;
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (finish && !cur_dis_reg && (cur_req_reg.opcode == ttps_pkg::OP_STORE)
                 && !cur_req_reg.time_expired && !keep)
        begin
            ram_we = 1'b1;
        end
    end

    ttps_ram #(
        .WIDTH (ttps_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == IDX_W'(TABLE_ENTRIES - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (work_valid)
                    begin
                        state_reg <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP:
                begin
                    if (!rsp_full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (work_pop)
        begin
            cur_req_reg <= w_req;
            cur_idx_reg <= w_idx;
            cur_dis_reg <= w_dis;
        end
    end

endmodule

>>> hw/rtl/transposition_table_probe_store.sv
// Transposition table with depth-preferred replacement, direct mapped.
// Request side: drive request and raise push; a transfer happens on a
// rising edge with push high and full low. opcode selects probe or store.
// Response side: while empty is low the oldest response is on response;
// a transfer happens on a rising edge with pop high and empty low.
// Every request yields exactly one response, in request order; a store
// answers with all fields zero.
// cfg_we with cfg_data loads the index mask; write it only while idle.
// A request passes the front index register, the work queue, the table RAM
// read and the response queue. The back end takes a new request only once the
// last has finished its table RAM read and any store write.
// After reset the table RAM is swept clear, one entry per cycle, over all
// TABLE_ENTRIES entries; full stays high during the sweep.
// When pop is held low the two-entry response queue and the work queue
// fill, then full rises; nothing is dropped.
module transposition_table_probe_store #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [ttps_pkg::MASK_W-1:0] cfg_data,
    input  logic                        push,
    input  ttps_pkg::req_t              request,
    output logic                        full,
    input  logic                        pop,
    output ttps_pkg::rsp_t              response,
    output logic                        empty
);

    localparam int WORK_W = ttps_pkg::REQ_W + $clog2(TABLE_ENTRIES) + 1;

    logic              clearing;
    logic              work_push;
    logic [WORK_W-1:0] work_wdata;
    logic              work_full;
    logic              work_pop;
    logic [WORK_W-1:0] work_rdata;
    logic              work_empty;
    logic              rsp_push;
    ttps_pkg::rsp_t    rsp_data;
    logic              rsp_full;
    logic [ttps_pkg::RSP_W-1:0] rsp_rdata;

    ttps_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .push      (push),
        .request   (request),
        .full      (full),
        .clearing  (clearing),
        .work_push (work_push),
        .work_data (work_wdata),
        .work_full (work_full)
    );

    ttps_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (2)
    ) u_work_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (work_push),
        .wdata (work_wdata),
        .full  (work_full),
        .pop   (work_pop),
        .rdata (work_rdata),
        .empty (work_empty)
    );

    ttps_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (!work_empty),
        .work_data  (work_rdata),
        .work_pop   (work_pop),
        .clearing   (clearing),
        .rsp_push   (rsp_push),
        .rsp_data   (rsp_data),
        .rsp_full   (rsp_full)
    );

    ttps_fifo #(
        .WIDTH (ttps_pkg::RSP_W),
        .DEPTH (2)
    ) u_rsp_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rsp_push),
        .wdata (rsp_data),
        .full  (rsp_full),
        .pop   (pop),
        .rdata (rsp_rdata),
        .empty (empty)
    );

    assign response = ttps_pkg::rsp_t'(rsp_rdata);

endmodule
